@@ rtl/skw_pkg.sv @@
// package: fixed-point constants, codes and arithmetic helpers for the kernel weight block
`default_nettype none
package skw_pkg;

    localparam int QF = 28;
    localparam logic [28:0] QONE = 29'd1 << QF;
    localparam logic [31:0] QRND = 32'd1 << (QF - 1);
    localparam logic [31:0] QPI_HALF = 32'd421657428;
    localparam logic [31:0] QNORM = 32'd107090258;
    localparam logic [31:0] QHALF = 32'd1 << (QF - 1);
    localparam logic [31:0] WMAX = 32'hFFFF_FFFF;
    localparam int RECIP_SH = 40;

    typedef enum logic [3:0] {
        KT_CONST    = 4'd0,
        KT_TRI      = 4'd1,
        KT_EPAN     = 4'd2,
        KT_TREXP    = 4'd3,
        KT_BIWEIGHT = 4'd4,
        KT_TRICUBE  = 4'd5,
        KT_COS      = 4'd6,
        KT_NORMAL   = 4'd7,
        KT_LAPLACE  = 4'd8,
        KT_HYPER    = 4'd9
    } kernel_t;

    typedef enum logic [0:0] {
        CFG_KERNEL_TYPE   = 1'b0,
        CFG_INVERSE_SCALE = 1'b1
    } cfg_index_t;

    // ceil(2^40 / k) for the exp series divisors
    localparam logic [40:0] EXP_RECIP [1:12] = '{
        41'(((64'd1 << RECIP_SH) + 64'd0) / 64'd1),
        41'(((64'd1 << RECIP_SH) + 64'd1) / 64'd2),
        41'(((64'd1 << RECIP_SH) + 64'd2) / 64'd3),
        41'(((64'd1 << RECIP_SH) + 64'd3) / 64'd4),
        41'(((64'd1 << RECIP_SH) + 64'd4) / 64'd5),
        41'(((64'd1 << RECIP_SH) + 64'd5) / 64'd6),
        41'(((64'd1 << RECIP_SH) + 64'd6) / 64'd7),
        41'(((64'd1 << RECIP_SH) + 64'd7) / 64'd8),
        41'(((64'd1 << RECIP_SH) + 64'd8) / 64'd9),
        41'(((64'd1 << RECIP_SH) + 64'd9) / 64'd10),
        41'(((64'd1 << RECIP_SH) + 64'd10) / 64'd11),
        41'(((64'd1 << RECIP_SH) + 64'd11) / 64'd12)
    };

    // ceil(2^40 / ((2k-1)*2k)) for the cosine series divisors
    localparam logic [40:0] COS_RECIP [1:10] = '{
        41'(((64'd1 << RECIP_SH) + 64'd1) / 64'd2),
        41'(((64'd1 << RECIP_SH) + 64'd11) / 64'd12),
        41'(((64'd1 << RECIP_SH) + 64'd29) / 64'd30),
        41'(((64'd1 << RECIP_SH) + 64'd55) / 64'd56),
        41'(((64'd1 << RECIP_SH) + 64'd89) / 64'd90),
        41'(((64'd1 << RECIP_SH) + 64'd131) / 64'd132),
        41'(((64'd1 << RECIP_SH) + 64'd181) / 64'd182),
        41'(((64'd1 << RECIP_SH) + 64'd239) / 64'd240),
        41'(((64'd1 << RECIP_SH) + 64'd305) / 64'd306),
        41'(((64'd1 << RECIP_SH) + 64'd379) / 64'd380)
    };

    function automatic logic [31:0] mulq(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] pr;
        pr = 64'(a) * 64'(b) + 64'(QRND);
        return pr[QF + 31:QF];
    endfunction

    function automatic logic [28:0] one_minus(input logic [31:0] x);
        logic [28:0] r;
        if (x >= 32'(QONE)) begin
            r = '0;
        end else begin
            r = 29'(32'(QONE) - x);
        end
        return r;
    endfunction

    // exact floor division for dividends below 2^31
    function automatic logic [30:0] divc(input logic [30:0] x, input logic [40:0] m);
        logic [71:0] pr;
        pr = 72'(x) * 72'(m);
        return pr[RECIP_SH + 30:RECIP_SH];
    endfunction

    function automatic logic [28:0] exp_one();
        logic [28:0] r;
        logic [31:0] pd;
        r = QONE;
        for (int k = 12; k >= 1; k--) begin
            pd = mulq(32'(QONE), 32'(r));
            r = one_minus(32'(divc(31'(pd), EXP_RECIP[k])));
        end
        return r;
    endfunction

    localparam logic [28:0] QE1 = exp_one();

endpackage
`default_nettype wire

@@ rtl/smoothing_kernel_weight.sv @@
// top level: pipelined smoothing kernel weight evaluator
//
// One sample is taken per clock while the output is not stalled, and every
// sample gives exactly one weight; the depth is set by the two-stage steps of
// the 12-term exp series (the 10-term cosine series runs beside it), the
// 31-stage chain of exp(-1) products and the bit-per-stage divider for the
// hyperbolic kernel that shares those stages. The whole pipeline advances
// whenever the output register is empty or being taken, so a stall on the
// result side holds every stage and loses nothing. kernel_type and
// inverse_scale are live registers and should be written while the pipeline
// is empty.
`default_nettype none
module smoothing_kernel_weight
    import skw_pkg::*;
#(
    parameter int IN_FRAC_BITS  = 16,
    parameter int OUT_FRAC_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,     // sample
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,     // weight
    output logic       [0:0] m_tuser,     // saturated
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic  [0:0] cfg_index,
    input  wire logic [23:0] cfg_data
);

    localparam int NUMW = IN_FRAC_BITS + OUT_FRAC_BITS + 1;
    localparam int USH = QF - IN_FRAC_BITS;
    localparam int ZS_R = (IN_FRAC_BITS >= 12) ? IN_FRAC_BITS - 12 : 0;
    localparam int ZS_L = (IN_FRAC_BITS < 12) ? 12 - IN_FRAC_BITS : 0;
    localparam logic [48:0] ZRND = (49'd1 << ZS_R) >> 1;
    localparam int OSH = QF - OUT_FRAC_BITS;
    localparam int NSH = QF + 16 - OUT_FRAC_BITS;
    localparam int NMID = 55;
    localparam int NV = 5 + NMID + 1 + 2;

    typedef struct packed {
        logic             last;
        logic             in_rng;
        logic [27:0]      u;
        logic [23:0]      mag;
        logic [28:0]      qpoly;
        logic [27:0]      f;
        logic [4:0]       n;
        logic             ezero;
        logic [28:0]      er;
        logic [30:0]      ep;
        logic [29:0]      cs;
        logic [28:0]      cr;
        logic [30:0]      cp;
        logic [NUMW-1:0]  dnum;
        logic [23:0]      drem;
        logic [NUMW-1:0]  dquo;
    } mid_t;

    logic [3:0]  kt_reg;
    logic [23:0] inv_reg;
    logic        adv;
    logic [NV-1:0] vld_reg, vld_next;

    // configuration
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kt_reg  <= 4'(KT_CONST);
            inv_reg <= 24'd65536;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                CFG_KERNEL_TYPE:   kt_reg <= cfg_data[3:0];
                CFG_INVERSE_SCALE: inv_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign adv = !vld_reg[NV-1] || m_tready;
    assign s_tready = adv;
    assign vld_next = {vld_reg[NV-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: magnitude, scaled product, divider numerator
    logic [23:0] mag1_next, f1_mag_reg;
    logic        rng1_next, f1_rng_reg, f1_last_reg;
    logic [27:0] u1_next, f1_u_reg;
    logic [47:0] p1_next, f1_p_reg;
    logic [NUMW-1:0] num1_next, f1_num_reg;

    always_comb begin
        mag1_next = s_tdata[23] ? (~s_tdata + 24'd1) : s_tdata;
        rng1_next = {1'b0, mag1_next} < (25'd1 << IN_FRAC_BITS);
        u1_next = rng1_next ? (28'(mag1_next) << USH) : 28'd0;
        p1_next = 48'(mag1_next) * 48'(inv_reg);
        num1_next = (NUMW'(1) << (IN_FRAC_BITS + OUT_FRAC_BITS)) + NUMW'(mag1_next >> 1);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f1_last_reg <= s_tlast;
            f1_mag_reg  <= mag1_next;
            f1_rng_reg  <= rng1_next;
            f1_u_reg    <= u1_next;
            f1_p_reg    <= p1_next;
            f1_num_reg  <= num1_next;
        end
    end

    // stage 2: clamp and align scaled argument, u squared, theta
    logic [34:0] z2_next, f2_z_reg;
    logic [28:0] uu2_next, f2_uu_reg, th2_next, f2_th_reg;
    logic        f2_last_reg, f2_rng_reg;
    logic [23:0] f2_mag_reg;
    logic [27:0] f2_u_reg;
    logic [NUMW-1:0] f2_num_reg;

    always_comb begin
        if (f1_p_reg >= (48'd64 << (IN_FRAC_BITS + 16))) begin
            z2_next = 35'd64 << QF;
        end else begin
            z2_next = 35'(((49'(f1_p_reg) + ZRND) >> ZS_R) << ZS_L);
        end
        uu2_next = 29'(mulq(32'(f1_u_reg), 32'(f1_u_reg)));
        th2_next = 29'(mulq(32'(f1_u_reg), QPI_HALF));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f2_last_reg <= f1_last_reg;
            f2_mag_reg  <= f1_mag_reg;
            f2_rng_reg  <= f1_rng_reg;
            f2_u_reg    <= f1_u_reg;
            f2_num_reg  <= f1_num_reg;
            f2_z_reg    <= z2_next;
            f2_uu_reg   <= uu2_next;
            f2_th_reg   <= th2_next;
        end
    end

    // stage 3: normal argument, polynomial terms, theta squared
    logic        zbig3_next, f3_zbig_reg;
    logic [62:0] zz3;
    logic [32:0] an3_next, f3_an_reg;
    logic [28:0] t3_next, f3_t_reg, uuu3_next, f3_uuu_reg;
    logic [29:0] cs3_next, f3_cs_reg;
    logic        f3_last_reg, f3_rng_reg;
    logic [23:0] f3_mag_reg;
    logic [27:0] f3_u_reg;
    logic [34:0] f3_z_reg;
    logic [NUMW-1:0] f3_num_reg;

    always_comb begin
        zbig3_next = f2_z_reg >= (35'd8 << QF);
        zz3 = 63'(f2_z_reg[30:0]) * 63'(f2_z_reg[30:0]) + (63'd1 << QF);
        an3_next = 33'(zz3 >> (QF + 1));
        t3_next = one_minus(32'(f2_uu_reg));
        uuu3_next = 29'(mulq(32'(f2_uu_reg), 32'(f2_u_reg)));
        cs3_next = 30'(mulq(32'(f2_th_reg), 32'(f2_th_reg)));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f3_last_reg <= f2_last_reg;
            f3_mag_reg  <= f2_mag_reg;
            f3_rng_reg  <= f2_rng_reg;
            f3_u_reg    <= f2_u_reg;
            f3_num_reg  <= f2_num_reg;
            f3_z_reg    <= f2_z_reg;
            f3_zbig_reg <= zbig3_next;
            f3_an_reg   <= an3_next;
            f3_t_reg    <= t3_next;
            f3_uuu_reg  <= uuu3_next;
            f3_cs_reg   <= cs3_next;
        end
    end

    // stage 4: exp argument select, biweight, tricube base
    logic [34:0] a4;
    logic        ez4_next, f4_ez_reg;
    logic [28:0] bq4_next, f4_bq_reg, tc4_next, f4_tc_reg, f4_t_reg;
    logic        f4_last_reg, f4_rng_reg;
    logic [23:0] f4_mag_reg;
    logic [27:0] f4_u_reg, f4_f_reg;
    logic [4:0]  f4_n_reg;
    logic [29:0] f4_cs_reg;
    logic [NUMW-1:0] f4_num_reg;

    always_comb begin
        case (kernel_t'(kt_reg))
            KT_TREXP:   a4 = 35'(f3_u_reg);
            KT_NORMAL:  a4 = f3_zbig_reg ? (35'd32 << QF) : 35'(f3_an_reg);
            KT_LAPLACE: a4 = f3_z_reg;
            default:    a4 = '0;
        endcase
        ez4_next = a4 >= (35'd32 << QF);
        bq4_next = 29'(mulq(32'(f3_t_reg), 32'(f3_t_reg)));
        tc4_next = one_minus(32'(f3_uuu_reg));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f4_last_reg <= f3_last_reg;
            f4_mag_reg  <= f3_mag_reg;
            f4_rng_reg  <= f3_rng_reg;
            f4_u_reg    <= f3_u_reg;
            f4_num_reg  <= f3_num_reg;
            f4_f_reg    <= a4[QF-1:0];
            f4_n_reg    <= a4[QF+4:QF];
            f4_ez_reg   <= ez4_next;
            f4_cs_reg   <= f3_cs_reg;
            f4_t_reg    <= f3_t_reg;
            f4_bq_reg   <= bq4_next;
            f4_tc_reg   <= tc4_next;
        end
    end

    // stage 5: tricube square
    logic [28:0] tt5_next, f5_tt_reg, f5_tc_reg, f5_t_reg, f5_bq_reg;
    logic        f5_last_reg, f5_rng_reg, f5_ez_reg;
    logic [23:0] f5_mag_reg;
    logic [27:0] f5_u_reg, f5_f_reg;
    logic [4:0]  f5_n_reg;
    logic [29:0] f5_cs_reg;
    logic [NUMW-1:0] f5_num_reg;

    assign tt5_next = 29'(mulq(32'(f4_tc_reg), 32'(f4_tc_reg)));

    always_ff @(posedge aclk) begin
        if (adv) begin
            f5_last_reg <= f4_last_reg;
            f5_mag_reg  <= f4_mag_reg;
            f5_rng_reg  <= f4_rng_reg;
            f5_u_reg    <= f4_u_reg;
            f5_num_reg  <= f4_num_reg;
            f5_f_reg    <= f4_f_reg;
            f5_n_reg    <= f4_n_reg;
            f5_ez_reg   <= f4_ez_reg;
            f5_cs_reg   <= f4_cs_reg;
            f5_t_reg    <= f4_t_reg;
            f5_bq_reg   <= f4_bq_reg;
            f5_tc_reg   <= f4_tc_reg;
            f5_tt_reg   <= tt5_next;
        end
    end

    // stage 6: polynomial kernels settled, series start
    mid_t        mid_reg [0:NMID];
    mid_t        mid_next [0:NMID];
    logic [28:0] tq6;

    always_comb begin
        tq6 = 29'(mulq(32'(f5_tt_reg), 32'(f5_tc_reg)));
        mid_next[0] = '0;
        mid_next[0].last = f5_last_reg;
        mid_next[0].in_rng = f5_rng_reg;
        mid_next[0].u = f5_u_reg;
        mid_next[0].mag = f5_mag_reg;
        case (kernel_t'(kt_reg))
            KT_CONST:    mid_next[0].qpoly = QONE;
            KT_TRI:      mid_next[0].qpoly = f5_rng_reg ? (QONE - 29'(f5_u_reg)) : 29'd0;
            KT_EPAN:     mid_next[0].qpoly = f5_rng_reg ? f5_t_reg : 29'd0;
            KT_BIWEIGHT: mid_next[0].qpoly = f5_rng_reg ? f5_bq_reg : 29'd0;
            KT_TRICUBE:  mid_next[0].qpoly = f5_rng_reg ? tq6 : 29'd0;
            default:     mid_next[0].qpoly = 29'd0;
        endcase
        mid_next[0].f = f5_f_reg;
        mid_next[0].n = f5_n_reg;
        mid_next[0].ezero = f5_ez_reg;
        mid_next[0].er = QONE;
        mid_next[0].cs = f5_cs_reg;
        mid_next[0].cr = QONE;
        mid_next[0].dnum = f5_num_reg;
    end

    // series steps, exp(-1) chain and divider share these stages
    genvar j;
    for (j = 1; j <= NMID; j++) begin : g_mid
        localparam int S = j - 1;
        localparam int KE = (S < 24) ? 12 - S / 2 : 1;
        localparam int KC = (S < 24 && KE <= 10) ? KE : 1;
        localparam int CI = (S >= 24) ? S - 24 : 0;
        logic [24:0] rs;
        logic        ge;

        always_comb begin
            mid_next[j] = mid_reg[j-1];
            rs = '0;
            ge = 1'b0;
            if (S < 24) begin
                if (S % 2 == 0) begin
                    mid_next[j].ep = 31'(mulq(32'(mid_reg[j-1].f), 32'(mid_reg[j-1].er)));
                    if (KE <= 10) begin
                        mid_next[j].cp = 31'(mulq(32'(mid_reg[j-1].cs),
                                                  32'(mid_reg[j-1].cr)));
                    end
                end else begin
                    mid_next[j].er = one_minus(32'(divc(mid_reg[j-1].ep, EXP_RECIP[KE])));
                    if (KE <= 10) begin
                        mid_next[j].cr = one_minus(32'(divc(mid_reg[j-1].cp,
                                                            COS_RECIP[KC])));
                    end
                end
            end else if (5'(CI) < mid_reg[j-1].n) begin
                mid_next[j].er = 29'(mulq(32'(mid_reg[j-1].er), 32'(QE1)));
            end
            if (S < NUMW) begin
                rs = {mid_reg[j-1].drem, mid_reg[j-1].dnum[NUMW-1]};
                ge = rs >= {1'b0, mid_reg[j-1].mag};
                mid_next[j].drem = ge ? 24'(rs - {1'b0, mid_reg[j-1].mag}) : 24'(rs);
                mid_next[j].dquo = {mid_reg[j-1].dquo[NUMW-2:0], ge};
                mid_next[j].dnum = mid_reg[j-1].dnum << 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i <= NMID; i++) begin
                mid_reg[i] <= mid_next[i];
            end
        end
    end

    // final product: exp kernels, cosine, pass-through
    mid_t        ml;
    logic [28:0] e7;
    logic [28:0] q7_next, g1_q_reg;
    logic        g1_last_reg, g1_mz_reg;
    logic [NUMW-1:0] g1_dquo_reg;

    always_comb begin
        ml = mid_reg[NMID];
        e7 = ml.ezero ? 29'd0 : ml.er;
        case (kernel_t'(kt_reg))
            KT_TREXP:   q7_next = ml.in_rng ?
                            29'(mulq(32'(QONE - 29'(ml.u)), 32'(e7))) : 29'd0;
            KT_COS:     q7_next = ml.in_rng ? ml.cr : 29'd0;
            KT_NORMAL:  q7_next = 29'(mulq(QNORM, 32'(e7)));
            KT_LAPLACE: q7_next = 29'(mulq(QHALF, 32'(e7)));
            default:    q7_next = ml.qpoly;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            g1_last_reg <= ml.last;
            g1_mz_reg   <= ml.mag == 24'd0;
            g1_dquo_reg <= ml.dquo;
            g1_q_reg    <= q7_next;
        end
    end

    // output conversion and saturation
    logic [53:0] ws;
    logic [29:0] wr;
    logic [31:0] w_next, m_tdata_reg;
    logic        sat_next, m_tuser_reg, m_tlast_reg;

    always_comb begin
        ws = '0;
        wr = '0;
        w_next = '0;
        sat_next = 1'b0;
        case (kernel_t'(kt_reg))
            KT_CONST, KT_TRI, KT_EPAN, KT_TREXP, KT_BIWEIGHT, KT_TRICUBE, KT_COS: begin
                wr = (30'(g1_q_reg) + (30'd1 << (OSH - 1))) >> OSH;
                w_next = 32'(wr);
            end
            KT_NORMAL, KT_LAPLACE: begin
                ws = (54'(g1_q_reg) * 54'(inv_reg) + (54'd1 << (NSH - 1))) >> NSH;
                sat_next = ws > 54'(WMAX);
                w_next = sat_next ? WMAX : ws[31:0];
            end
            KT_HYPER: begin
                sat_next = g1_mz_reg || (64'(g1_dquo_reg) > 64'(WMAX));
                w_next = sat_next ? WMAX : 32'(g1_dquo_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= w_next;
            m_tuser_reg <= sat_next;
            m_tlast_reg <= g1_last_reg;
        end
    end

    assign m_tvalid = vld_reg[NV-1];
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;
    assign m_tlast = m_tlast_reg;

endmodule
`default_nettype wire

@@ tb/sv/skw_checker.sv @@
// checker: watches the sample, weight and register channels, predicts each weight and compares
`timescale 1ns / 1ps
`default_nettype none
module skw_checker
    import skw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic  [0:0] m_tuser,
    input  wire logic        m_tlast,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic  [0:0] cfg_index,
    input  wire logic [23:0] cfg_data,
    output int               pending,
    output int               failures
);

    typedef bit [63:0] u64;

    localparam int IN_FB  = 16;
    localparam int OUT_FB = 16;
    localparam u64 ONE    = u64'(1) << QF;

    typedef struct {
        bit [31:0] weight;
        bit        saturated;
        bit        last;
    } weight_t;

    weight_t   weights_due[$];
    bit  [3:0] kernel_sel;
    bit [23:0] scale_recip;

    function automatic u64 qmul(u64 a, u64 b);
        return (a * b + (u64'(1) << (QF - 1))) >> QF;
    endfunction

    function automatic u64 round_shift(u64 v, int sh);
        if (sh == 0) return v;
        return (v + (u64'(1) << (sh - 1))) >> sh;
    endfunction

    function automatic u64 floor_one_minus(u64 term);
        return term >= ONE ? 64'd0 : ONE - term;
    endfunction

    function automatic u64 exp_taylor(u64 f);
        u64 r;
        r = ONE;
        for (int k = 12; k >= 1; k--) r = floor_one_minus(qmul(f, r) / u64'(k));
        return r;
    endfunction

    function automatic u64 exp_decay(u64 a);
        u64 r;
        u64 e1;
        if (a >= 32 * ONE) return 0;
        r  = exp_taylor(a & (ONE - 1));
        e1 = exp_taylor(ONE);
        for (u64 i = 0; i < (a >> QF); i++) r = qmul(r, e1);
        return r;
    endfunction

    function automatic u64 cosine_q(u64 u);
        u64 th;
        u64 s;
        u64 r;
        th = qmul(u, u64'(QPI_HALF));
        s  = qmul(th, th);
        r  = ONE;
        for (int k = 10; k >= 1; k--) r = floor_one_minus(qmul(s, r) / u64'((2*k-1)*(2*k)));
        return r;
    endfunction

    function automatic weight_t kernel_weight(bit [23:0] x, bit last);
        weight_t res;
        u64 mag, u, q, t, w, z, a, p;
        bit in_unit;
        mag = x[23] ? u64'(25'h1000000 - x) : u64'(x);
        in_unit = mag < (u64'(1) << IN_FB);
        u = in_unit ? mag << (QF - IN_FB) : 0;
        q = 0;
        w = 0;
        case (kernel_sel)
            KT_CONST:    q = ONE;
            KT_TRI:      q = in_unit ? ONE - u : 0;
            KT_EPAN:     q = in_unit ? floor_one_minus(qmul(u, u)) : 0;
            KT_TREXP:    q = in_unit ? qmul(ONE - u, exp_decay(u)) : 0;
            KT_BIWEIGHT: begin
                t = floor_one_minus(qmul(u, u));
                q = in_unit ? qmul(t, t) : 0;
            end
            KT_TRICUBE:  begin
                t = floor_one_minus(qmul(qmul(u, u), u));
                q = in_unit ? qmul(qmul(t, t), t) : 0;
            end
            KT_COS:      q = in_unit ? cosine_q(u) : 0;
            default:     q = 0;
        endcase
        if (kernel_sel <= KT_COS) w = round_shift(q, QF - OUT_FB);
        if (kernel_sel == KT_NORMAL || kernel_sel == KT_LAPLACE) begin
            p = mag * u64'(scale_recip);
            if (p >= (u64'(64) << (IN_FB + 16))) z = 64 * ONE;
            else z = round_shift(p, IN_FB + 16 - QF);
            if (kernel_sel == KT_NORMAL) begin
                a = (z >= 8 * ONE) ? 32 * ONE : (z * z + ONE) >> (QF + 1);
                p = qmul(u64'(QNORM), exp_decay(a));
            end else begin
                p = qmul(u64'(QHALF), exp_decay(z));
            end
            w = round_shift(p * u64'(scale_recip), QF + 16 - OUT_FB);
        end
        if (kernel_sel == KT_HYPER) begin
            if (mag == 0) w = u64'(WMAX) + 1;
            else w = ((u64'(1) << (IN_FB + OUT_FB)) + (mag >> 1)) / mag;
        end
        res.saturated = w > u64'(WMAX);
        res.weight    = res.saturated ? WMAX : w[31:0];
        res.last      = last;
        return res;
    endfunction

    assign pending = weights_due.size();

    always @(posedge aclk) begin
        weight_t due;
        if (!aresetn) begin
            kernel_sel  <= KT_CONST;
            scale_recip <= 24'd65536;
            failures    <= 0;
            weights_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_KERNEL_TYPE) kernel_sel <= cfg_data[3:0];
                else scale_recip <= cfg_data;
            end
            if (s_tvalid && s_tready) weights_due.push_back(kernel_weight(s_tdata, s_tlast));
            if (m_tvalid && m_tready) begin
                if (weights_due.size() == 0) begin
                    $error("weight transfer with nothing expected: %h", m_tdata);
                    failures <= failures + 1;
                end else begin
                    due = weights_due.pop_front();
                    if (m_tdata !== due.weight || m_tuser[0] !== due.saturated
                            || m_tlast !== due.last) begin
                        if (m_tdata !== due.weight)
                            $error("weight: expected %h, got %h", due.weight, m_tdata);
                        if (m_tuser[0] !== due.saturated)
                            $error("saturated: expected %b, got %b", due.saturated, m_tuser);
                        if (m_tlast !== due.last)
                            $error("last: expected %b, got %b", due.last, m_tlast);
                        failures <= failures + 1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// testbench top: clock, reset, register and sample stimulus, result stalls and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import skw_pkg::*;

    localparam int LATENCY   = 63;
    localparam int IDLE_LIMIT = 5000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic  [0:0] m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic  [0:0] cfg_index = CFG_KERNEL_TYPE;
    logic [23:0] cfg_data = '0;
    int          pending;
    int          failures;
    int          idle_cycles = 0;

    smoothing_kernel_weight i_dut (.*);

    skw_checker i_checker (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // result-side stalls
    initial begin
        int n;
        forever begin
            m_tready <= 1'b1;
            n = gap_len();
            repeat ($urandom_range(30, 1)) @(posedge aclk);
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_sample(logic [23:0] x, logic last);
        int g;
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        s_tlast  <= last;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    function automatic logic [23:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 24'($urandom_range(65535)) ^ ($urandom_range(1) ? 24'hFFFFFF : 24'h0);
        if (r < 70) return 24'($urandom_range(255)) ^ ($urandom_range(1) ? 24'hFFFFFF : 24'h0);
        if (r < 85) return 24'($urandom_range(1 << 19)) ^ ($urandom_range(1) ? 24'hFFFFFF : 24'h0);
        return 24'($urandom);
    endfunction

    initial begin
        logic [23:0] edge_samples [12] = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h00FFFF,
            24'hFF0001, 24'h010000, 24'hFF0000, 24'h008000, 24'hFF8000, 24'h7FFFFF,
            24'h800000, 24'h800001};
        logic [23:0] scales [6] = '{24'd65536, 24'd1, 24'hFFFFFF, 24'd16384,
            24'd262144, 24'd4096};
        int phases;
        int per_phase;
        phases = 22;
        per_phase = (1800 - 12) / phases - 8;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // reset values, directed edges
        foreach (edge_samples[i]) send_sample(edge_samples[i], i[0]);
        for (int ph = 0; ph < phases; ph++) begin
            drain();
            write_reg(CFG_KERNEL_TYPE, 24'(ph < 16 ? ph : $urandom_range(9, 7)));
            write_reg(CFG_INVERSE_SCALE, scales[ph % 6]);
            foreach (edge_samples[i]) if (i < 8) send_sample(edge_samples[i], i[0]);
            for (int n = 0; n < per_phase; n++) begin
                if (ph == 3 && n == per_phase / 2) drain();
                send_sample(pick_sample(), $urandom_range(1));
            end
        end
        drain();
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire

@@ filelist.f @@
rtl/skw_pkg.sv
rtl/smoothing_kernel_weight.sv
tb/sv/skw_checker.sv
tb/sv/tb_top.sv
